/* rtl/core/acc_pkg.sv */
`default_nettype none

package acc_pkg;

	// protocol constants
	localparam logic [7:0] CLAIM_TIMEOUT_MS     = 8'd250;
	localparam logic [7:0] LAST_DYNAMIC_ADDRESS = 8'd247;
	localparam logic [7:0] NULL_ADDR            = 8'd254;

	// reset values
	localparam logic [7:0] TICK_MS_RESET        = 8'd10;
	localparam logic [7:0] START_ADDRESS_RESET  = 8'd128;
	localparam logic [7:0] NEXT_CANDIDATE_RESET = 8'd127;

	// request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_CLAIM   = 2'd1;
	localparam logic [1:0] REQ_OWN_SA  = 2'd2;
	localparam logic [1:0] REQ_CONTEND = 2'd3;

	// claim machine modes
	localparam logic [2:0] MODE_INIT         = 3'd0;
	localparam logic [2:0] MODE_WAIT         = 3'd1;
	localparam logic [2:0] MODE_RECLAIM      = 3'd2;
	localparam logic [2:0] MODE_CANNOT       = 3'd3;
	localparam logic [2:0] MODE_CANNOT_DELAY = 3'd4;
	localparam logic [2:0] MODE_NORMAL       = 3'd5;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_NAME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd2;

	// divider geometry: (name sum mod 255) * 6 fits in 11 bits
	localparam int unsigned DIVIDEND_W = 11;
	localparam int unsigned DIV_CNT_W  = 4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] contender_name;
		logic        bus_off;
		logic        tx_accepted;
	} in_word_t;

	typedef struct packed {
		logic       claim_sent;
		logic [7:0] claim_address;
		logic [7:0] current_address;
		logic [2:0] mode;
		logic       address_claimed;
	} out_word_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/acc_backoff_div.sv */
`default_nettype none

module acc_backoff_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] name,
	input  wire logic [7:0]  divisor,
	output logic      [7:0]  quotient,
	output logic             done
);
	import acc_pkg::*;

	logic [DIVIDEND_W-1:0] sum_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [7:0]            rem_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  prep_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVIDEND_W-1:0] byte_sum;
	logic [8:0]            fold;
	logic [7:0]            mod255;
	logic [DIVIDEND_W-1:0] dividend;
	logic [8:0]            rem_sh;
	logic                  q_bit;
	logic [8:0]            rem_sub;

	// sum of the eight name bytes
	always_comb begin
		byte_sum = '0;
		for (int i = 0; i < 8; i++) begin
			byte_sum = byte_sum + {3'b000, name[8*i +: 8]};
		end
	end

	// mod 255 by folding the high bits back in (256 is 1 mod 255), then times 6
	always_comb begin
		fold = {1'b0, sum_q[7:0]} + {6'b000000, sum_q[10:8]};
		if (fold >= 9'd255) begin
			mod255 = 8'(fold - 9'd255);
		end else begin
			mod255 = fold[7:0];
		end
		dividend = {1'b0, mod255, 2'b00} + {2'b00, mod255, 1'b0};
	end

	// one restoring step
	always_comb begin
		rem_sh  = {rem_q, quot_q[DIVIDEND_W-1]};
		q_bit   = (rem_sh >= {1'b0, divisor});
		rem_sub = rem_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			prep_q <= 1'b1;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (prep_q) begin
			prep_q <= 1'b0;
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= byte_sum;
		end else if (prep_q) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= q_bit ? rem_sub[7:0] : rem_sh[7:0];
			quot_q <= {quot_q[DIVIDEND_W-2:0], q_bit};
		end
	end

	// zero divisor saturates to all ones
	assign quotient = (divisor == 8'd0) ? 8'hFF : quot_q[7:0];
	assign done     = done_q;

endmodule

`default_nettype wire

/* rtl/core/acc_datapath.sv */
`default_nettype none

module acc_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire acc_pkg::ctrl_cmd_t            cmd,
	output acc_pkg::dp_sts_t                   sts,
	input  wire acc_pkg::in_word_t             in_data,
	input  wire logic                          cfg_we,
	input  wire logic [acc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output acc_pkg::out_word_t                 out_data
);
	import acc_pkg::*;

	// configuration
	logic [63:0] own_name_q;
	logic [7:0]  tick_q;

	// claim machine state
	logic [2:0]  ms_q;
	logic [7:0]  held_q;
	logic [7:0]  nc_q;
	logic [7:0]  timer_q;
	logic [7:0]  backoff_q;
	logic        claimed_q;
	logic        req_q;
	logic        own_q;
	logic        cont_q;
	logic [63:0] rival_q;

	in_word_t    item_q;
	out_word_t   out_q;
	logic        out_valid_q;

	logic [7:0]  bo;
	logic        div_done;

	logic [2:0]  ms_d;
	logic [7:0]  held_d;
	logic [7:0]  nc_d;
	logic [7:0]  timer_d;
	logic [7:0]  backoff_d;
	logic        claimed_d;
	logic        req_d;
	logic        own_d;
	logic        cont_d;
	logic        sent;
	logic [7:0]  sent_addr;
	logic        do_resolve;
	logic        loss;
	logic [7:0]  cand;
	logic        delay_ok;

	acc_backoff_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.name     (own_name_q),
		.divisor  (tick_q),
		.quotient (bo),
		.done     (div_done)
	);

	always_comb begin
		loss     = (rival_q <= own_name_q);
		cand     = nc_q + 8'd1;
		if (cand > LAST_DYNAMIC_ADDRESS) begin
			cand = NULL_ADDR;
		end
		delay_ok = (backoff_q < tick_q);
	end

	always_comb begin
		ms_d       = ms_q;
		held_d     = held_q;
		nc_d       = nc_q;
		timer_d    = timer_q;
		backoff_d  = backoff_q;
		claimed_d  = claimed_q;
		req_d      = req_q;
		own_d      = own_q;
		cont_d     = cont_q;
		sent       = 1'b0;
		sent_addr  = 8'd0;
		do_resolve = 1'b0;
		case (item_q.req_type)
			REQ_CLAIM: begin
				req_d = 1'b1;
			end
			REQ_OWN_SA: begin
				own_d = 1'b1;
			end
			REQ_CONTEND: begin
				cont_d = 1'b1;
			end
			default: begin
				case (ms_q)
					MODE_WAIT: begin
						if (item_q.bus_off) begin
							timer_d   = tick_q;
							backoff_d = bo;
							ms_d      = MODE_RECLAIM;
						end else if (cont_q) begin
							timer_d    = tick_q;
							do_resolve = 1'b1;
						end else if (timer_q == CLAIM_TIMEOUT_MS) begin
							timer_d   = tick_q;
							claimed_d = 1'b1;
							ms_d      = MODE_NORMAL;
						end else begin
							timer_d = timer_q + tick_q;
						end
					end
					MODE_RECLAIM, MODE_CANNOT_DELAY: begin
						if (delay_ok) begin
							if (item_q.tx_accepted) begin
								sent      = 1'b1;
								sent_addr = held_q;
								ms_d      = (ms_q == MODE_RECLAIM) ? MODE_WAIT : MODE_CANNOT;
							end
						end else begin
							backoff_d = backoff_q - tick_q;
						end
					end
					MODE_CANNOT: begin
						if (req_q) begin
							backoff_d = bo;
							req_d     = 1'b0;
							ms_d      = MODE_CANNOT_DELAY;
						end
					end
					MODE_NORMAL: begin
						if (req_q || own_q) begin
							if (item_q.tx_accepted) begin
								sent      = 1'b1;
								sent_addr = held_q;
								req_d     = 1'b0;
								own_d     = 1'b0;
							end
						end else if (cont_q) begin
							do_resolve = 1'b1;
						end
					end
					default: begin
						// init, and the unused codes
						if (item_q.tx_accepted) begin
							sent      = 1'b1;
							sent_addr = held_q;
							ms_d      = MODE_WAIT;
						end
					end
				endcase
			end
		endcase

		// contention: a lost arbitration moves on to the next address first
		if (do_resolve) begin
			if (loss) begin
				nc_d   = cand;
				held_d = cand;
				if (cand == NULL_ADDR) begin
					ms_d = MODE_CANNOT;
				end
			end
			if (item_q.tx_accepted) begin
				sent      = 1'b1;
				sent_addr = loss ? cand : held_q;
				cont_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_name_q   <= '0;
			tick_q       <= TICK_MS_RESET;
			ms_q         <= MODE_INIT;
			held_q       <= START_ADDRESS_RESET;
			nc_q         <= NEXT_CANDIDATE_RESET;
			timer_q      <= TICK_MS_RESET;
			backoff_q    <= '0;
			claimed_q    <= 1'b0;
			req_q        <= 1'b0;
			own_q        <= 1'b0;
			cont_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN_NAME: begin
						own_name_q <= cfg_data;
					end
					CFG_TICK_MS: begin
						tick_q <= cfg_data[7:0];
						if (ms_q == MODE_INIT) begin
							timer_q <= cfg_data[7:0];
						end
					end
					// start address only matters as a reload of the held address in init
					CFG_START_ADDRESS: begin
						if (ms_q == MODE_INIT) begin
							held_q <= cfg_data[7:0];
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				ms_q        <= ms_d;
				held_q      <= held_d;
				nc_q        <= nc_d;
				timer_q     <= timer_d;
				backoff_q   <= backoff_d;
				claimed_q   <= claimed_d;
				req_q       <= req_d;
				own_q       <= own_d;
				cont_q      <= cont_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= in_data;
		end
		if (cmd.commit && (item_q.req_type == REQ_CONTEND)) begin
			rival_q <= item_q.contender_name;
		end
		if (cmd.commit) begin
			out_q.claim_sent      <= sent;
			out_q.claim_address   <= sent_addr;
			out_q.current_address <= held_d;
			out_q.mode            <= ms_d;
			out_q.address_claimed <= claimed_d;
		end
	end

	assign sts.need_div = (item_q.req_type == REQ_TICK)
		&& (((ms_q == MODE_WAIT) && item_q.bus_off) || ((ms_q == MODE_CANNOT) && req_q));
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* rtl/core/acc_ctrl.sv */
`default_nettype none

module acc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire acc_pkg::dp_sts_t  sts,
	output acc_pkg::ctrl_cmd_t     cmd
);
	import acc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_DECODE;
						in_ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					state_q <= sts.need_div ? ST_DIV : ST_COMMIT;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (!sts.out_busy) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready      = in_ready_q;
	assign cmd.load_in   = in_valid && in_ready_q;
	assign cmd.div_start = (state_q == ST_DECODE) && sts.need_div;
	assign cmd.commit    = (state_q == ST_COMMIT) && !sts.out_busy;

endmodule

`default_nettype wire

/* rtl/core/address_claim_controller_top.sv */
// a result word is registered after the sequencer's decode and commit states; a tick that starts a
//   backoff first waits on the bit-serial divider (prep, 11 quotient bits, done check)
// the input is not ready for a new word until the last one is committed, and the
//   sequencer holds in commit while a result waits on out_ready
// reset: arst_n clears all control state at once; config registers go to their
//   defaults and the claim machine to init, with no clearing pass
`default_nettype none

module address_claim_controller_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input word channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire acc_pkg::in_word_t             in_data,
	// result word channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output acc_pkg::out_word_t                 out_data,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [acc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data
);
	import acc_pkg::*;

	// command and status between sequencer and datapath
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: accept, decode, optional divide, then commit when the
	// output register is free; one word can wait in commit behind an unread result
	acc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: config registers, claim machine state, backoff divider and
	// the output register
	acc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* tb/address_claim_checker.sv */
`timescale 1ns / 100ps

module address_claim_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire acc_pkg::in_word_t             in_data,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire acc_pkg::out_word_t            out_data,
	input  wire logic                          cfg_we,
	input  wire logic [acc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	output int unsigned                        mismatch_count,
	output int unsigned                        words_owed
);
	import acc_pkg::*;

	// register copies
	logic [63:0] name_q;
	logic [7:0]  tick_q;
	logic [7:0]  start_q;

	// claim machine copy
	logic [2:0]  st;
	logic [7:0]  addr_q;
	logic [7:0]  cand_q;
	logic [7:0]  timer_q;
	logic [7:0]  backoff_q;
	logic        claimed_q;
	logic        req_pend;
	logic        own_sa_pend;
	logic        contend_pend;
	logic [63:0] rival_q;
	logic        sent_now;
	logic [7:0]  sent_addr;

	out_word_t   owed_q[$];
	out_word_t   oldest;

	// pseudo-random backoff from the name bytes
	function automatic logic [7:0] backoff_ticks();
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < 8; i++)
			sum += name_q[8*i +: 8];
		sum = (sum % 255) * 6;
		if (tick_q == 8'd0)
			return 8'hFF;
		return 8'(sum / tick_q);
	endfunction

	function automatic logic offer_claim(input logic acc);
		if (acc) begin
			sent_now = 1'b1;
			sent_addr = addr_q;
		end
		return acc;
	endfunction

	function automatic void judge_rival(input logic acc);
		logic [7:0] nxt;
		// equal names lose too
		if (rival_q <= name_q) begin
			nxt = cand_q + 8'd1;
			if (nxt > LAST_DYNAMIC_ADDRESS)
				nxt = NULL_ADDR;
			cand_q = nxt;
			addr_q = nxt;
			if (nxt == NULL_ADDR)
				st = MODE_CANNOT;
		end
		if (offer_claim(acc))
			contend_pend = 1'b0;
	endfunction

	function automatic void count_down(input logic [2:0] target, input logic acc);
		if (backoff_q < tick_q) begin
			if (offer_claim(acc))
				st = target;
		end else begin
			backoff_q = backoff_q - tick_q;
		end
	endfunction

	function automatic out_word_t predict_word(input in_word_t w);
		out_word_t r;
		sent_now = 1'b0;
		sent_addr = '0;
		case (w.req_type)
			REQ_CLAIM: req_pend = 1'b1;
			REQ_OWN_SA: own_sa_pend = 1'b1;
			REQ_CONTEND: begin
				rival_q = w.contender_name;
				contend_pend = 1'b1;
			end
			default: begin
				case (st)
					MODE_WAIT: begin
						if (w.bus_off) begin
							timer_q = tick_q;
							backoff_q = backoff_ticks();
							st = MODE_RECLAIM;
						end else if (contend_pend) begin
							timer_q = tick_q;
							judge_rival(w.tx_accepted);
						end else if (timer_q == CLAIM_TIMEOUT_MS) begin
							timer_q = tick_q;
							claimed_q = 1'b1;
							st = MODE_NORMAL;
						end else begin
							timer_q = timer_q + tick_q;
						end
					end
					MODE_RECLAIM: count_down(MODE_WAIT, w.tx_accepted);
					MODE_CANNOT: begin
						if (req_pend) begin
							backoff_q = backoff_ticks();
							req_pend = 1'b0;
							st = MODE_CANNOT_DELAY;
						end
					end
					MODE_CANNOT_DELAY: count_down(MODE_CANNOT, w.tx_accepted);
					MODE_NORMAL: begin
						if (req_pend || own_sa_pend) begin
							if (offer_claim(w.tx_accepted)) begin
								req_pend = 1'b0;
								own_sa_pend = 1'b0;
							end
						end else if (contend_pend) begin
							judge_rival(w.tx_accepted);
						end
					end
					// init and the unused codes
					default: begin
						if (offer_claim(w.tx_accepted))
							st = MODE_WAIT;
					end
				endcase
			end
		endcase
		r.claim_sent = sent_now;
		r.claim_address = sent_now ? sent_addr : 8'd0;
		r.current_address = addr_q;
		r.mode = st;
		r.address_claimed = claimed_q;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			name_q = '0;
			tick_q = TICK_MS_RESET;
			start_q = START_ADDRESS_RESET;
			st = MODE_INIT;
			addr_q = START_ADDRESS_RESET;
			cand_q = NEXT_CANDIDATE_RESET;
			timer_q = TICK_MS_RESET;
			backoff_q = '0;
			claimed_q = 1'b0;
			req_pend = 1'b0;
			own_sa_pend = 1'b0;
			contend_pend = 1'b0;
			rival_q = '0;
			owed_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN_NAME: name_q = cfg_data;
					CFG_TICK_MS: begin
						tick_q = cfg_data[7:0];
						if (st == MODE_INIT)
							timer_q = tick_q;
					end
					CFG_START_ADDRESS: begin
						start_q = cfg_data[7:0];
						if (st == MODE_INIT)
							addr_q = start_q;
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				owed_q.push_back(predict_word(in_data));
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("result word with none expected: %p", out_data);
					mismatch_count++;
				end else begin
					oldest = owed_q.pop_front();
					check_field("claim_sent", 8'(oldest.claim_sent),
						8'(out_data.claim_sent));
					check_field("claim_address", oldest.claim_address,
						out_data.claim_address);
					check_field("current_address", oldest.current_address,
						out_data.current_address);
					check_field("mode", 8'(oldest.mode), 8'(out_data.mode));
					check_field("address_claimed", 8'(oldest.address_claimed),
						8'(out_data.address_claimed));
				end
			end
		end
		words_owed <= unsigned'(owed_q.size());
	end

endmodule

/* tb/tb_address_claim_controller_top.sv */
`timescale 1ns / 100ps

module tb_address_claim_controller_top;
	import acc_pkg::*;

	// cycles with no word moving on either channel before giving up
	localparam int unsigned IDLE_LIMIT   = 2000;
	// quiet cycles after the last result, well past the divider latency
	localparam int unsigned DRAIN_CYCLES = 40;
	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
	localparam logic [63:0] NAME_ALL_ONES = '1;

	typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [63:0]           cfg_data;

	int unsigned mismatch_count;
	int unsigned words_owed;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_cycles = 0;
	logic [63:0] own_name_now = '0;
	// mode carried by the last result word, steers the exhaustion phase
	logic [2:0]  seen_mode = MODE_INIT;

	address_claim_controller_top u_top (.*);

	address_claim_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk)
		if (out_valid && out_ready)
			seen_mode <= out_data.mode;

	// watchdog: no word moved for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [63:0] rand_name();
		return {$urandom, $urandom};
	endfunction

	function automatic in_word_t word_of(input logic [1:0] req, input logic [63:0] name,
		input logic bus_off, input logic acc);
		in_word_t w;
		w.req_type = req;
		w.contender_name = name;
		w.bus_off = bus_off;
		w.tx_accepted = acc;
		return w;
	endfunction

	// offer one word; valid stays up between back-to-back words
	task automatic push_word(input in_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// stop sending and wait for every owed result word
	task automatic drain_words();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (words_owed != 0);
	endtask

	// quiesce, rewrite all registers, then switch the pacing
	task automatic begin_phase(input pace_t pace, input logic [63:0] name,
		input logic [7:0] tick, input logic [7:0] start);
		drain_words();
		own_name_now = name;
		cfg_we <= 1'b1;
		cfg_index <= CFG_OWN_NAME;
		cfg_data <= name;
		@(posedge clk);
		// upper data bits are junk, only the low byte counts
		cfg_index <= CFG_TICK_MS;
		cfg_data <= {$urandom, 24'($urandom), tick};
		@(posedge clk);
		cfg_index <= CFG_START_ADDRESS;
		cfg_data <= {$urandom, 24'($urandom), start};
		@(posedge clk);
		// write to the unmapped index must do nothing
		cfg_index <= CFG_NONE;
		cfg_data <= rand_name();
		@(posedge clk);
		cfg_we <= 1'b0;
		case (pace)
			PACE_SRC_IDLE: begin
				gap_pct = 82;
				stall_pct = 0;
			end
			PACE_SINK_STALL: begin
				gap_pct = 0;
				stall_pct = 82;
			end
			PACE_BOTH: begin
				gap_pct = 16;
				stall_pct = 16;
			end
			default: begin
				gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// random word mix; contend takes whatever percentage is left
	task automatic run_mix(input int unsigned count, input int unsigned pct_tick,
		input int unsigned pct_claim, input int unsigned pct_own,
		input int unsigned pct_busoff, input int unsigned pct_accept,
		input logic until_cannot);
		int unsigned n;
		int unsigned pick;
		logic [63:0] rival;
		n = 0;
		while (n < count && !(until_cannot &&
			(seen_mode == MODE_CANNOT || seen_mode == MODE_CANNOT_DELAY))) begin
			pick = $urandom_range(99);
			// rival names near ours hit the equal and off-by-one compares
			case ($urandom_range(3))
				0: rival = rand_name();
				1: rival = own_name_now;
				2: rival = own_name_now + 64'd1;
				default: rival = own_name_now - 64'd1;
			endcase
			if (pick < pct_tick)
				push_word(word_of(REQ_TICK, rand_name(), $urandom_range(99) < pct_busoff,
					$urandom_range(99) < pct_accept));
			else if (pick < pct_tick + pct_claim)
				push_word(word_of(REQ_CLAIM, rival, 1'($urandom), 1'($urandom)));
			else if (pick < pct_tick + pct_claim + pct_own)
				push_word(word_of(REQ_OWN_SA, rival, 1'($urandom), 1'($urandom)));
			else
				push_word(word_of(REQ_CONTEND, rival, 1'($urandom), 1'($urandom)));
			n++;
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: smallest nonzero tick and start address 0 while in init
		begin_phase(PACE_FULL, 64'd0, 8'd1, 8'd0);
		// bus-off and a refused frame leave init alone
		push_word(word_of(REQ_TICK, NAME_ALL_ONES, 1'b1, 1'b0));
		// events in init only set pending flags
		push_word(word_of(REQ_CLAIM, 64'd0, 1'b1, 1'b1));
		push_word(word_of(REQ_OWN_SA, NAME_ALL_ONES, 1'b0, 1'b1));
		push_word(word_of(REQ_CONTEND, 64'd0, 1'b1, 1'b0));

		// still init: tick and start address reload on write
		begin_phase(PACE_FULL, NAME_ALL_ONES, 8'd255, 8'd253);
		// first claim at 253, machine enters wait
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b1));
		// pending rival of name zero wins, frame refused so it stays pending
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b0));
		// loses again, this time the frame goes out
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b1));
		// rival with a name equal to ours
		push_word(word_of(REQ_CONTEND, NAME_ALL_ONES, 1'b0, 1'b0));
		// bus-off takes priority over the pending contention
		push_word(word_of(REQ_TICK, 64'd0, 1'b1, 1'b1));
		// reclaim frame refused, then sent and back to wait
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b0));
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b1));
		// equal-name loss resolved now
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b1));
		// leave the window timer at 255 so a step of 4 or 8 never lands on the timeout
		push_word(word_of(REQ_TICK, NAME_ALL_ONES, 1'b1, 1'b1));
		push_word(word_of(REQ_TICK, 64'd0, 1'b0, 1'b1));

		// wait and reclaim delay: steps of 4 and 8 keep the window open
		begin_phase(PACE_SRC_IDLE, rand_name(), 8'd4, 8'd0);
		run_mix(150, 70, 10, 10, 5, 75, 1'b0);
		begin_phase(PACE_SINK_STALL, rand_name(), 8'd8, 8'd253);
		run_mix(120, 70, 10, 10, 5, 75, 1'b0);

		// steps that reach the timeout quickly, then normal traffic
		case ($urandom_range(2))
			0: begin_phase(PACE_BOTH, rand_name(), 8'd25, 8'($urandom_range(253)));
			1: begin_phase(PACE_BOTH, rand_name(), 8'd125, 8'($urandom_range(253)));
			default: begin_phase(PACE_BOTH, rand_name(), 8'd255, 8'($urandom_range(253)));
		endcase
		run_mix(150, 85, 5, 5, 3, 70, 1'b0);

		// largest name loses every compare: run the addresses out
		begin_phase(PACE_FULL, NAME_ALL_ONES, 8'($urandom_range(1, 255)),
			8'($urandom_range(253)));
		run_mix(400, 60, 3, 2, 5, 30, 1'b1);

		// cannot claim and its backoff delay
		begin_phase(PACE_SRC_IDLE, rand_name(), 8'($urandom_range(20, 255)),
			8'($urandom_range(253)));
		run_mix(80, 70, 15, 8, 5, 60, 1'b0);
		begin_phase(PACE_SINK_STALL, rand_name(), 8'd255, 8'($urandom_range(253)));
		run_mix(80, 70, 15, 8, 5, 60, 1'b0);

		drain_words();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
